>>> hw/rtl/bcpd_pkg.sv
// Shared types and constants for the button click and press detector.
package bcpd_pkg;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_LONG   = 3'd3,
        EV_XLONG  = 3'd4,
        EV_SINGLE = 3'd5,
        EV_DOUBLE = 3'd6,
        EV_TRIPLE = 3'd7
    } event_t;

    localparam int unsigned CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_LEVEL  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AUTO_REPEAT   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLICK_WINDOW  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_THRESH   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_TICKS    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_XLONG_TICKS   = 3'd6;

    localparam int unsigned TALLY_WIDTH = 3;
    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = 3'd4;

endpackage

>>> hw/rtl/button_click_press_detector.sv
// Button debounce, multi-click and long-press detector top level.
//
// Usage:
//   Input channel (in_valid/in_ready/pin_sample) takes one raw pin sample per
//   request; each request is one tick of the debounce and hold counters.
//   Output channel (out_valid/out_ready/event_code/fresh_press/is_pressed)
//   returns exactly one result per input request, in order.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one
//   register per request; cfg_ready is always high. Write only while idle.
// Pipeline: an accepted request waits in the input register, then its
//   result is captured in the result register.
// Throughput: one request per cycle when not stalled; the tick update
//   is one compare-and-count pass between input and result registers.
// Reset: all counters, the debounced state and the click tally clear, and
//   the registers take their default values.
// Stall: when out_ready is low the result register holds; the input
//   register still fills, and in_ready drops only once both are full.
module button_click_press_detector #(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 pin_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           event_code,
    output logic                                 fresh_press,
    output logic                                 is_pressed,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0]               cfg_data
);

    localparam int unsigned TICK_WIDTH = COUNT_WIDTH + 1;

    logic                   active_level_reg;
    logic                   auto_repeat_reg;
    logic [COUNT_WIDTH-1:0] debounce_count_reg;
    logic [COUNT_WIDTH-1:0] click_window_reg;
    logic [COUNT_WIDTH-1:0] hold_thresh_reg;
    logic [COUNT_WIDTH-1:0] long_ticks_reg;
    logic [COUNT_WIDTH-1:0] xlong_ticks_reg;

    logic                   in_valid_reg;
    logic                   pin_reg;

    logic                   stable_active_reg, stable_active_next;
    logic [COUNT_WIDTH-1:0] debounce_cnt_reg, debounce_cnt_next;
    logic [TICK_WIDTH-1:0]  hold_ticks_reg, hold_ticks_next;
    logic                   pressed_reg, pressed_next;
    logic [bcpd_pkg::TALLY_WIDTH-1:0] tally_reg, tally_next;

    logic                   out_valid_reg;
    bcpd_pkg::event_t       event_reg, event_next;
    logic                   fresh_reg, fresh_next;
    logic                   is_pressed_reg;

    logic                   result_free;
    logic                   advance;
    logic                   sample_active;
    logic [COUNT_WIDTH-1:0] debounce_inc;
    logic [TICK_WIDTH-1:0]  hold_inc;

    assign cfg_ready   = 1'b1;
    assign result_free = !out_valid_reg || out_ready;
    assign advance     = in_valid_reg && result_free;
    assign in_ready    = !in_valid_reg || result_free;

    assign out_valid   = out_valid_reg;
    assign event_code  = event_reg;
    assign fresh_press = fresh_reg;
    assign is_pressed  = is_pressed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg   <= 1'b0;
            auto_repeat_reg    <= 1'b0;
            debounce_count_reg <= COUNT_WIDTH'(3);
            click_window_reg   <= COUNT_WIDTH'(30);
            hold_thresh_reg    <= COUNT_WIDTH'(50);
            long_ticks_reg     <= COUNT_WIDTH'(100);
            xlong_ticks_reg    <= COUNT_WIDTH'(200);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bcpd_pkg::CFG_ACTIVE_LEVEL: active_level_reg   <= cfg_data[0];
                bcpd_pkg::CFG_AUTO_REPEAT:  auto_repeat_reg    <= cfg_data[0];
                bcpd_pkg::CFG_DEBOUNCE:     debounce_count_reg <= cfg_data;
                bcpd_pkg::CFG_CLICK_WINDOW: click_window_reg   <= cfg_data;
                bcpd_pkg::CFG_HOLD_THRESH:  hold_thresh_reg    <= cfg_data;
                bcpd_pkg::CFG_LONG_TICKS:   long_ticks_reg     <= cfg_data;
                bcpd_pkg::CFG_XLONG_TICKS:  xlong_ticks_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Input register: hold the sample until the result side can take it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pin_reg <= pin_sample;
        end
    end

    always_comb
    begin
        sample_active      = (pin_reg == active_level_reg);
        debounce_inc       = debounce_cnt_reg + COUNT_WIDTH'(1);
        stable_active_next = stable_active_reg;
        debounce_cnt_next  = COUNT_WIDTH'(0);
        hold_ticks_next    = hold_ticks_reg;
        pressed_next       = pressed_reg;
        tally_next         = tally_reg;
        event_next         = bcpd_pkg::EV_NONE;
        fresh_next         = 1'b0;

        // Debounce
        if (sample_active != stable_active_reg)
        begin
            debounce_cnt_next = debounce_inc;
            if (debounce_inc >= debounce_count_reg)
            begin
                stable_active_next = sample_active;
                debounce_cnt_next  = COUNT_WIDTH'(0);
            end
        end

        // Advance the tick counter until it passes the extra-long limit
        hold_inc = hold_ticks_reg + TICK_WIDTH'(1);
        if (hold_ticks_reg <= {1'b0, xlong_ticks_reg})
        begin
            hold_ticks_next = hold_inc;
        end

        if (pressed_reg)
        begin
            if (!stable_active_next)
            begin
                event_next   = bcpd_pkg::EV_UP;
                pressed_next = 1'b0;
                if (hold_ticks_next < {1'b0, click_window_reg} &&
                    tally_reg < bcpd_pkg::TALLY_MAX)
                begin
                    tally_next = tally_reg + bcpd_pkg::TALLY_WIDTH'(1);
                end
            end
            else if (hold_ticks_next >= {1'b0, hold_thresh_reg})
            begin
                if (auto_repeat_reg)
                begin
                    event_next      = bcpd_pkg::EV_DOWN;
                    hold_ticks_next = TICK_WIDTH'(0);
                end
                else if (hold_ticks_next == {1'b0, long_ticks_reg})
                begin
                    event_next = bcpd_pkg::EV_LONG;
                end
                else if (hold_ticks_next == {1'b0, xlong_ticks_reg})
                begin
                    event_next = bcpd_pkg::EV_XLONG;
                end
                tally_next = '0;
            end
        end
        else
        begin
            if (stable_active_next)
            begin
                hold_ticks_next = TICK_WIDTH'(0);
                event_next      = bcpd_pkg::EV_DOWN;
                fresh_next      = 1'b1;
                pressed_next    = 1'b1;
            end
            else if (hold_ticks_next > {1'b0, click_window_reg} && tally_reg != '0)
            begin
                case (tally_reg)
                    bcpd_pkg::TALLY_WIDTH'(1): event_next = bcpd_pkg::EV_SINGLE;
                    bcpd_pkg::TALLY_WIDTH'(2): event_next = bcpd_pkg::EV_DOUBLE;
                    bcpd_pkg::TALLY_WIDTH'(3): event_next = bcpd_pkg::EV_TRIPLE;
                    default:                   event_next = bcpd_pkg::EV_NONE;
                endcase
                tally_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_active_reg <= 1'b0;
            debounce_cnt_reg  <= '0;
            hold_ticks_reg    <= '0;
            pressed_reg       <= 1'b0;
            tally_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                stable_active_reg <= stable_active_next;
                debounce_cnt_reg  <= debounce_cnt_next;
                hold_ticks_reg    <= hold_ticks_next;
                pressed_reg       <= pressed_next;
                tally_reg         <= tally_next;
            end
            if (result_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg      <= event_next;
            fresh_reg      <= fresh_next;
            is_pressed_reg <= pressed_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= bcpd_pkg::TALLY_MAX)
        else $error("click tally above saturation");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fresh_reg) |-> (event_reg == bcpd_pkg::EV_DOWN && is_pressed_reg))
        else $error("fresh press without pressed down event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg == bcpd_pkg::EV_UP) |-> !is_pressed_reg)
        else $error("up event while still pressed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(event_reg)))
        else $error("stalled result changed");

endmodule
